### design/assert_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

### design/imcf_pkg.sv
// Types, constants and tables for the complementary attitude filter.
package imcf_pkg;
  localparam int CordicStepsDef = 16;
  localparam int AtanEntries = 24;
  localparam int Preshift = 14;
  localparam int CordicW = 36;
  localparam int AngW = 26;
  localparam int AlphaW = 17;
  localparam int PeriodW = 16;
  localparam int QueueDepth = 2;
  localparam logic [AlphaW-1:0] AlphaOne = 17'd65536;
  localparam logic [AlphaW-1:0] AlphaRst = 17'd41288;
  localparam logic [PeriodW-1:0] PeriodRst = 16'd328;
  localparam logic signed [AngW-1:0] Deg180 = 26'sd11796480;
  localparam logic CfgIdxAlpha = 1'b0;
  localparam logic CfgIdxPeriod = 1'b1;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] roll_deg;
    logic signed [31:0] pitch_deg;
    logic signed [31:0] yaw_deg;
  } out_word_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ROT, ST_BLEND, ST_OUT} be_state_t;

  function automatic logic signed [AngW-1:0] atan_lut(input logic [4:0] i);
    logic signed [AngW-1:0] v;
    case (i)
      5'd0: v = 26'sd2949120;  5'd1: v = 26'sd1740967;  5'd2: v = 26'sd919879;
      5'd3: v = 26'sd466945;   5'd4: v = 26'sd234379;   5'd5: v = 26'sd117304;
      5'd6: v = 26'sd58666;    5'd7: v = 26'sd29335;    5'd8: v = 26'sd14668;
      5'd9: v = 26'sd7334;     5'd10: v = 26'sd3667;    5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;     5'd13: v = 26'sd458;     5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;     5'd16: v = 26'sd57;      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;      5'd19: v = 26'sd7;       5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;       5'd22: v = 26'sd1;       default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    if (v > 50'sd2147483647) return 32'sh7fffffff;
    if (v < -50'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage

### design/imcf_front.sv
// Front end: input queue holding accepted samples for the back end.
module imcf_front import imcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     q_valid,
  input  logic     q_pop,
  output in_word_t q_data
);
  in_word_t mem_r [QueueDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push;

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

### design/imcf_back.sv
// Back end: gyro integration, dual CORDIC atan2 and blend per sample.
module imcf_back import imcf_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_pop,
  input  in_word_t          q_data,
  input  logic [AlphaW-1:0] alpha,
  input  logic [PeriodW-1:0] period,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data
);
  localparam int Steps = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;

  be_state_t st_r, st_nxt;
  logic [4:0] it_r;
  logic [1:0] bl_r;
  logic signed [CordicW-1:0] rx_r, ry_r, px_r, py_r;
  logic signed [AngW-1:0] rz_r, pz_r;
  logic signed [31:0] roll_r, pitch_r, yaw_r;
  logic signed [31:0] g_r [3];
  logic signed [31:0] n_r [3];
  logic signed [AngW-1:0] acc;
  logic signed [49:0] bsum;
  logic [AlphaW-1:0] a_eff;

  assign a_eff = (alpha > AlphaOne) ? AlphaOne : alpha;
  assign out_valid = (st_r == ST_OUT);
  assign out_data = '{roll_deg: roll_r, pitch_deg: pitch_r, yaw_deg: yaw_r};

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    case (st_r)
      ST_IDLE: if (q_valid) begin st_nxt = ST_ROT; q_pop = 1'b1; end
      ST_ROT: if (it_r == 5'(Steps - 1)) st_nxt = ST_BLEND;
      ST_BLEND: if (bl_r == 2'd2) st_nxt = ST_OUT;
      ST_OUT: if (out_ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // one blend multiply-add per cycle, one angle at a time
  always_comb begin
    case (bl_r)
      2'd0: acc = rz_r;
      2'd1: acc = pz_r;
      default: acc = '0;
    endcase
    bsum = $signed({1'b0, a_eff}) * g_r[bl_r]
         + $signed({1'b0, AlphaOne - a_eff}) * acc + 50'sd32768;
  end

  function automatic void rot(input logic signed [CordicW-1:0] x, y,
                              input logic signed [AngW-1:0] z, input logic [4:0] i,
                              output logic signed [CordicW-1:0] xo, yo,
                              output logic signed [AngW-1:0] zo);
    logic signed [CordicW-1:0] dx, dy;
    dx = y >>> i;
    dy = x >>> i;
    if (!y[CordicW-1]) begin
      xo = x + dx; yo = y - dy; zo = z + atan_lut(i);
    end else begin
      xo = x - dx; yo = y + dy; zo = z - atan_lut(i);
    end
  endfunction

  function automatic void pre(input logic signed [16:0] y, x,
                              output logic signed [CordicW-1:0] xo, yo,
                              output logic signed [AngW-1:0] zo);
    logic signed [17:0] xa, ya;
    xa = x; ya = y; zo = '0;
    if (x < 0) begin
      zo = (y >= 0) ? Deg180 : -Deg180;
      xa = -xa; ya = -ya;
    end
    xo = CordicW'(xa) <<< Preshift;
    yo = CordicW'(ya) <<< Preshift;
  endfunction

  always_ff @(posedge clk) begin
    logic signed [CordicW-1:0] a, b, c, d;
    logic signed [AngW-1:0] e, f;
    if (!rst_n) begin
      st_r <= ST_IDLE; it_r <= '0; bl_r <= '0;
      roll_r <= '0; pitch_r <= '0; yaw_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: if (q_valid) begin
          pre(-17'(q_data.accel_x), 17'(q_data.accel_z), a, b, e);
          rx_r <= a; ry_r <= b; rz_r <= e;
          pre(17'(q_data.accel_y), 17'(q_data.accel_z), c, d, f);
          px_r <= c; py_r <= d; pz_r <= f;
          g_r[0] <= sat32(50'(roll_r) + $signed({1'b0, period}) * q_data.rate_x);
          g_r[1] <= sat32(50'(pitch_r) + $signed({1'b0, period}) * q_data.rate_y);
          g_r[2] <= sat32(50'(yaw_r) + $signed({1'b0, period}) * q_data.rate_z);
          it_r <= '0; bl_r <= '0;
        end
        ST_ROT: begin
          // the both-zero case keeps x and y zero, so z stays at 0
          if (rx_r != 0 || ry_r != 0) begin
            rot(rx_r, ry_r, rz_r, it_r, a, b, e);
            rx_r <= a; ry_r <= b; rz_r <= e;
          end
          if (px_r != 0 || py_r != 0) begin
            rot(px_r, py_r, pz_r, it_r, c, d, f);
            px_r <= c; py_r <= d; pz_r <= f;
          end
          it_r <= it_r + 5'd1;
        end
        ST_BLEND: begin
          n_r[bl_r] <= sat32(bsum >>> 16);
          bl_r <= bl_r + 2'd1;
          if (bl_r == 2'd2) begin
            roll_r <= n_r[0]; pitch_r <= n_r[1]; yaw_r <= sat32(bsum >>> 16);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

### design/imu_complementary_filter.sv
// Top level of the complementary attitude filter.
// Usage:
//  - in_valid/in_ready move one six-axis sample word (in_data). A two-entry
//    queue in the front end takes words while the back end is busy.
//  - out_valid/out_ready move one result word: roll, pitch, yaw in signed
//    Q15.16 degrees; one result per sample, in order.
//  - cfg_we/cfg_idx/cfg_wdata write blend weight (0) and sample period (1);
//    write only while idle.
// Flow: a sample is loaded from the queue, runs the shared two-lane CORDIC
// rotation loop for CORDIC_STEPS iterations (capped at AtanEntries), passes
// its three angles through the single blend multiplier one at a time and is
// then handed off. The back end takes no new sample until the result is
// handed off; the next word waits in the queue until the load pops it.
// Reset: angles clear to zero, registers load 0.63 and 0.005, queue empties.
// A stalled receiver holds the result; the back end waits, the queue fills,
// then in_ready drops.
`include "assert_macros.svh"
module imu_complementary_filter import imcf_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic        cfg_idx,
  input  logic [16:0] cfg_wdata
);
  logic [AlphaW-1:0] alpha_r;
  logic [PeriodW-1:0] period_r;
  logic q_valid, q_pop;
  in_word_t q_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= AlphaRst; period_r <= PeriodRst;
    end else if (cfg_we) begin
      case (cfg_idx)
        CfgIdxAlpha: alpha_r <= cfg_wdata;
        CfgIdxPeriod: period_r <= cfg_wdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  imcf_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_valid, .q_pop, .q_data
  );

  imcf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_data,
    .alpha(alpha_r), .period(period_r),
    .out_valid, .out_ready, .out_data
  );

  `ASSERT_IMPL(a_pop_needs_data, clk, rst_n, q_pop, q_valid)
  `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `ASSERT_IMPL(a_no_pop_while_out, clk, rst_n, out_valid, !q_pop)
endmodule
